// ----- hw/rtl/prps_pkg.sv -----
`timescale 1ns / 1ps
package prps_pkg;

  localparam int unsigned NumRegs   = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 31;
  localparam int unsigned Reach     = 200;
  localparam int unsigned BaseIndex = 24;
  localparam int unsigned GlowGain  = 140;

  typedef enum logic [CfgIdxW-1:0] {
    RegWavePhases = 3'd0,
    RegGlowParams = 3'd1,
    RegRipple0    = 3'd2,
    RegRipple1    = 3'd3,
    RegRipple2    = 3'd4,
    RegRipple3    = 3'd5
  } reg_idx_e;

  localparam logic [23:0] GlowReset = 24'h008080;

  // sine table, folded from a quarter wave and signed by idx[7]
  function automatic logic signed [7:0] sine_at(input logic [7:0] idx);
    logic [6:0] q;
    logic [6:0] a;
    logic [6:0] v;
    q = idx[6:0];
    a = (q <= 7'd64) ? q : 7'(8'd128 - {1'b0, q});
    unique case (a)
      7'd0: v = 0;    7'd1: v = 3;    7'd2: v = 6;    7'd3: v = 9;
      7'd4: v = 12;   7'd5: v = 15;   7'd6: v = 18;   7'd7: v = 21;
      7'd8: v = 24;   7'd9: v = 27;   7'd10: v = 30;  7'd11: v = 33;
      7'd12: v = 36;  7'd13: v = 39;  7'd14: v = 42;  7'd15: v = 45;
      7'd16: v = 48;  7'd17: v = 51;  7'd18: v = 54;  7'd19: v = 57;
      7'd20: v = 59;  7'd21: v = 62;  7'd22: v = 65;  7'd23: v = 67;
      7'd24: v = 70;  7'd25: v = 73;  7'd26: v = 75;  7'd27: v = 78;
      7'd28: v = 80;  7'd29: v = 82;  7'd30: v = 85;  7'd31: v = 87;
      7'd32: v = 89;  7'd33: v = 91;  7'd34: v = 94;  7'd35: v = 96;
      7'd36: v = 98;  7'd37: v = 100; 7'd38: v = 102; 7'd39: v = 103;
      7'd40: v = 105; 7'd41: v = 107; 7'd42: v = 108; 7'd43: v = 110;
      7'd44: v = 112; 7'd45: v = 113; 7'd46: v = 114; 7'd47: v = 116;
      7'd48: v = 117; 7'd49: v = 118; 7'd50: v = 119; 7'd51: v = 120;
      7'd52: v = 121; 7'd53: v = 122; 7'd54: v = 123; 7'd55: v = 123;
      7'd56: v = 124; 7'd57: v = 125; 7'd58: v = 125; 7'd59: v = 126;
      7'd60: v = 126; 7'd61: v = 126; 7'd62: v = 126; 7'd63: v = 126;
      7'd64: v = 127;
      default: v = 0;
    endcase
    return idx[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic [7:0] stop_ch(input logic [1:0] s, input logic [1:0] k);
    logic [7:0] v;
    unique case ({s, k})
      4'h0: v = 2;   4'h1: v = 4;   4'h2: v = 18;
      4'h4: v = 0;   4'h5: v = 70;  4'h6: v = 120;
      4'h8: v = 40;  4'h9: v = 210; 4'ha: v = 215;
      4'hc: v = 250; 4'hd: v = 240; 4'he: v = 255;
      default: v = 0;
    endcase
    return v;
  endfunction

  // gradient palette entry, byte-swapped rgb565
  function automatic logic [15:0] palette_at(input logic [7:0] i);
    logic [9:0] t;
    logic [1:0] seg;
    logic [7:0] f;
    logic signed [9:0] a;
    logic signed [9:0] b;
    logic signed [19:0] p;
    logic [7:0] ch [3];
    logic [15:0] c;
    t = 10'(i) * 10'd3;
    seg = t[9:8];
    f = t[7:0];
    for (int k = 0; k < 3; k++) begin
      a = $signed({2'b0, stop_ch(seg, 2'(k))});
      b = $signed({2'b0, stop_ch(seg + 2'd1, 2'(k))});
      p = (b - a) * $signed({12'b0, f});
      ch[k] = 8'(a + 10'(p >>> 8));
    end
    c = {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
    return {c[7:0], c[15:8]};
  endfunction

  function automatic logic [8:0] oct2(input logic [7:0] px, input logic [7:0] py,
                                      input logic [7:0] gx, input logic [7:0] gy);
    logic [7:0] ax;
    logic [7:0] ay;
    ax = (px >= gx) ? px - gx : gx - px;
    ay = (py >= gy) ? py - gy : gy - py;
    return (ax > ay) ? 9'(ax) + 9'(ay >> 1) : 9'(ay) + 9'(ax >> 1);
  endfunction

endpackage

// ----- hw/rtl/prps_stream_if.sv -----
`timescale 1ns / 1ps
interface prps_stream_if #(
  parameter int unsigned Width = 16
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/plasma_ripple_pixel_shader.sv -----
`timescale 1ns / 1ps
// channel   dir  payload
// in_s      in   data[7:0] pixel_x, data[15:8] pixel_y
// out_m     out  data[15:0] pixel_color, data[23:16] palette_index
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// seven register stages: distances, sines, ring and glow products,
// window products, divide by reach, sum, clamp and palette
// one transaction per clock while out_m is not stalled
// reset clears valid bits and restores register defaults
// a stall on out_m holds every stage; ready is high whenever the output is free
module plasma_ripple_pixel_shader
  import prps_pkg::*;
#(
  parameter int unsigned RIPPLE_SLOTS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  prps_stream_if.sink         in_s,
  prps_stream_if.source       out_m
);

  localparam int unsigned Ns = 7;

  logic [23:0] wave_q;
  logic [23:0] glow_q;
  logic [30:0] rip_q [4];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
      glow_q <= GlowReset;
      for (int i = 0; i < 4; i++) rip_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWavePhases: wave_q <= cfg_data_i[23:0];
        RegGlowParams: glow_q <= cfg_data_i[23:0];
        RegRipple0:    rip_q[0] <= cfg_data_i;
        RegRipple1:    rip_q[1] <= cfg_data_i;
        RegRipple2:    rip_q[2] <= cfg_data_i;
        RegRipple3:    rip_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [Ns-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[Ns-1] || out_m.ready;
  assign in_s.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Ns-2:0], in_s.valid};
  end

  // stage 1: distances
  logic [7:0] x1_q, y1_q;
  logic [8:0] d1_q;
  logic [8:0] rd1_q [4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q <= in_s.data[7:0];
      y1_q <= in_s.data[15:8];
      d1_q <= oct2(in_s.data[7:0], in_s.data[15:8], glow_q[7:0], glow_q[15:8]);
      for (int i = 0; i < 4; i++)
        rd1_q[i] <= oct2(in_s.data[7:0], in_s.data[15:8], rip_q[i][7:0], rip_q[i][15:8]);
    end
  end

  // stage 2: sine lookups, glow, ripple windows and active flags
  logic signed [9:0] pl2_q;
  logic [7:0] g2_q;
  logic signed [7:0] rs2_q [4];
  logic [7:0] win2_q [4];
  logic [3:0] on2_q;
  logic [7:0] a1, a2, a3, a4;
  assign a1 = {x1_q[6:0], 1'b0} + wave_q[7:0];
  assign a2 = {y1_q[6:0], 1'b0} - wave_q[15:8];
  assign a3 = {7'(x1_q + y1_q), 1'b0} + wave_q[23:16];
  assign a4 = 8'(d1_q * 2'd3) - {wave_q[6:0], 1'b0};
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pl2_q <= 10'(sine_at(a1)) + 10'(sine_at(a2)) + 10'(sine_at(a3)) + 10'(sine_at(a4));
      g2_q  <= (d1_q > 9'd255) ? 8'd0 : 8'(9'd255 - d1_q);
      for (int i = 0; i < 4; i++) begin
        rs2_q[i]  <= sine_at(8'(rd1_q[i] * 3'd5) - rip_q[i][23:16]);
        win2_q[i] <= 8'(9'(Reach) - rd1_q[i]);
        on2_q[i]  <= (i < RIPPLE_SLOTS) && (rip_q[i][30:24] != 7'd0) && (rd1_q[i] < 9'(Reach));
      end
    end
  end

  // stage 3: ring amplitude, glow product and plasma over five
  logic signed [8:0] ring3_q [4];
  logic [7:0] win3_q [4];
  logic [16:0] gp3_q;
  logic signed [7:0] pq3_q;
  logic signed [9:0] gf;
  logic signed [17:0] gprod;
  logic signed [15:0] rp [4];
  logic [8:0] pm;
  logic [18:0] pp;
  assign gf = 10'sd140 + 10'($signed(glow_q[23:16]));
  assign gprod = $signed({10'b0, g2_q}) * $signed({{8{gf[9]}}, gf});
  // truncating divide by five: magnitude times 205, shifted down by 10
  assign pm = pl2_q[9] ? 9'(-pl2_q) : pl2_q[8:0];
  assign pp = 19'(pm) * 19'd205;
  always_comb begin
    for (int i = 0; i < 4; i++)
      rp[i] = 16'(rs2_q[i]) * $signed({9'b0, rip_q[i][30:24]});
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      gp3_q <= gprod[16:0];
      pq3_q <= pl2_q[9] ? -$signed({1'b0, pp[16:10]}) : $signed({1'b0, pp[16:10]});
      for (int i = 0; i < 4; i++) begin
        ring3_q[i] <= on2_q[i] ? 9'(rp[i] >>> 7) : 9'sd0;
        win3_q[i]  <= win2_q[i];
      end
    end
  end

  // stage 4: ring times window, kept as sign and magnitude
  logic [14:0] wm4_q [4];
  logic [3:0] wn4_q;
  logic [7:0] g4_q;
  logic signed [7:0] pq4_q;
  logic signed [17:0] wp [4];
  always_comb begin
    for (int i = 0; i < 4; i++)
      wp[i] = 18'(ring3_q[i]) * $signed({10'b0, win3_q[i]});
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      g4_q  <= gp3_q[16:9];
      pq4_q <= pq3_q;
      for (int i = 0; i < 4; i++) begin
        wn4_q[i] <= wp[i][17];
        wm4_q[i] <= wp[i][17] ? 15'(-wp[i]) : wp[i][14:0];
      end
    end
  end

  // stage 5: truncating divide by reach, magnitude times 5243, shifted down by 20
  logic signed [8:0] rq5_q [4];
  logic [7:0] g5_q;
  logic signed [7:0] pq5_q;
  logic [27:0] qm [4];
  always_comb begin
    for (int i = 0; i < 4; i++)
      qm[i] = 28'(wm4_q[i]) * 28'd5243;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      g5_q  <= g4_q;
      pq5_q <= pq4_q;
      for (int i = 0; i < 4; i++)
        rq5_q[i] <= wn4_q[i] ? -$signed({1'b0, qm[i][27:20]}) : $signed({1'b0, qm[i][27:20]});
    end
  end

  // stage 6: ripple sum, halved toward zero, and field index
  logic signed [10:0] idx6_q;
  logic signed [10:0] rsum;
  logic signed [10:0] rbias;
  logic signed [10:0] rhalf;
  always_comb begin
    rsum = '0;
    for (int i = 0; i < 4; i++)
      rsum = rsum + 11'(rq5_q[i]);
    rbias = rsum + $signed({10'b0, rsum[10]});
    rhalf = rbias >>> 1;
  end
  always_ff @(posedge clk_i) begin
    if (adv)
      idx6_q <= 11'(BaseIndex) + 11'(g5_q) + 11'(pq5_q) + rhalf;
  end

  // stage 7: clamp and palette
  logic [7:0] idx;
  logic [23:0] out_q;
  assign idx = idx6_q[10] ? 8'd0 : (idx6_q > 11'sd255 ? 8'd255 : idx6_q[7:0]);
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= {idx, palette_at(idx)};
  end

  assign out_m.valid = vld_q[Ns-1];
  assign out_m.data  = out_q;

endmodule

// ----- test/plasma_ripple_pixel_shader_tb.sv -----
`timescale 1ns / 1ps
module plasma_ripple_pixel_shader_tb;
  import prps_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 12;

  // local colour and sine tables, built independently of the package
  int quarter_wave [65] = '{
    0, 3, 6, 9, 12, 15, 18, 21, 24, 27, 30, 33, 36, 39, 42, 45,
    48, 51, 54, 57, 59, 62, 65, 67, 70, 73, 75, 78, 80, 82, 85, 87,
    89, 91, 94, 96, 98, 100, 102, 103, 105, 107, 108, 110, 112, 113, 114, 116,
    117, 118, 119, 120, 121, 122, 123, 123, 124, 125, 125, 126, 126, 126, 126, 126,
    127};
  int grad [4][3] = '{'{2, 4, 18}, '{0, 70, 120}, '{40, 210, 215}, '{250, 240, 255}};

  function automatic int wave(input int i);
    int q;
    int v;
    q = i & 127;
    v = (q <= 64) ? quarter_wave[q] : quarter_wave[128 - q];
    return ((i & 255) >= 128) ? -v : v;
  endfunction

  function automatic int floor_div(input int v, input int d);
    int r;
    r = v / d;
    if ((v % d) != 0 && v < 0) r = r - 1;
    return r;
  endfunction

  function automatic logic [15:0] gradient_colour(input int i);
    int seg;
    int f;
    int ch [3];
    logic [15:0] c;
    seg = (i * 3) >> 8;
    f = (i * 3) & 255;
    for (int k = 0; k < 3; k++)
      ch[k] = grad[seg][k] + floor_div((grad[seg+1][k] - grad[seg][k]) * f, 256);
    c = {5'(ch[0] >> 3), 6'(ch[1] >> 2), 5'(ch[2] >> 3)};
    return {c[7:0], c[15:8]};
  endfunction

  function automatic int octagon(input int dx, input int dy);
    int ax;
    int ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    return ax > ay ? ax + (ay >> 1) : ay + (ax >> 1);
  endfunction

  class shade_scoreboard;
    logic [30:0] regs [6];
    logic [23:0] pending [$];
    int errors;
    int shown;

    function new();
      regs[0] = '0;
      regs[1] = 31'(GlowReset);
      for (int i = 2; i < 6; i++) regs[i] = '0;
      errors = 0;
      shown = 0;
    endfunction

    function void write_reg(input int idx, input logic [30:0] v);
      if (idx == RegWavePhases || idx == RegGlowParams) regs[idx] = v & 31'hFF_FFFF;
      else if (idx < NumRegs) regs[idx] = v;
    endfunction

    // compute expected colour and index for one pixel
    function void note_pixel(input logic [7:0] px, input logic [7:0] py);
      int p1, p2, p3, gx, gy, breath, plasma, d, glow, rip, idx;
      int rx, ry, ph, env, rd, win, ring;
      p1 = regs[0][7:0]; p2 = regs[0][15:8]; p3 = regs[0][23:16];
      gx = regs[1][7:0]; gy = regs[1][15:8];
      breath = $signed(regs[1][23:16]);
      plasma = wave(px * 2 + p1) + wave(py * 2 - p2) + wave((px + py) * 2 + p3);
      d = octagon(px - gx, py - gy);
      plasma += wave(d * 3 - p1 * 2);
      glow = 255 - d;
      if (glow < 0) glow = 0;
      rip = 0;
      for (int i = 0; i < 4; i++) begin
        rx = regs[2+i][7:0]; ry = regs[2+i][15:8];
        ph = regs[2+i][23:16]; env = regs[2+i][30:24];
        if (env != 0) begin
          rd = octagon(px - rx, py - ry);
          win = Reach - rd;
          if (win > 0) begin
            ring = floor_div(wave(rd * 5 - ph) * env, 128);
            rip += ring * win / int'(Reach);
          end
        end
      end
      idx = int'(BaseIndex) + ((glow * (int'(GlowGain) + breath)) >>> 9) + plasma / 5
          + rip / 2;
      if (idx < 0) idx = 0;
      if (idx > 255) idx = 255;
      pending.push_back({8'(idx), gradient_colour(idx)});
    endfunction

    function void check_result(input logic [23:0] got);
      logic [23:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result %h", got);
        end
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: colour exp %h got %h, index exp %0d got %0d",
                   want[15:0], got[15:0], want[23:16], got[23:16]);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int idle_cycles = 0;
  bit stall_mode = 1'b0;
  shade_scoreboard board;

  prps_stream_if #(.Width(16)) pix_if ();
  prps_stream_if #(.Width(24)) col_if ();

  plasma_ripple_pixel_shader dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_s(pix_if.sink), .out_m(col_if.source)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    pix_if.valid = 1'b0;
    pix_if.data = '0;
    col_if.ready = 1'b0;
  end

  // monitor: note accepted inputs and check results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) board.note_pixel(pix_if.data[7:0], pix_if.data[15:8]);
      if (col_if.valid && col_if.ready) board.check_result(col_if.data);
      if ((pix_if.valid && pix_if.ready) || (col_if.valid && col_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern, sometimes always ready
  always @(negedge clk_i) begin
    if (!stall_mode) col_if.ready <= 1'b1;
    else col_if.ready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("plasma_ripple_pixel_shader_tb failed");
      $finish;
    end
  end

  task automatic write_cfg(input reg_idx_e idx, input logic [30:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    board.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // one pixel transaction; valid stays high into the next call
  task automatic send_pixel(input logic [7:0] x, input logic [7:0] y);
    pix_if.valid <= 1'b1;
    pix_if.data <= {y, x};
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    pix_if.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  function automatic logic [30:0] rand_ripple();
    logic [30:0] r;
    r = 31'($urandom);
    if ($urandom_range(0, 5) == 0) r[30:24] = 7'd0;
    if ($urandom_range(0, 5) == 0) r[30:24] = 7'h7F;
    return r;
  endfunction

  task automatic random_phase(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && left > 0; i++, left--)
        send_pixel(8'($urandom), 8'($urandom));
      if ($urandom_range(0, 2) != 0) end_burst();
    end
    pix_if.valid <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: corners and centre at reset settings
    send_pixel(8'h00, 8'h00); send_pixel(8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00); send_pixel(8'h00, 8'hFF);
    send_pixel(8'h80, 8'h80); send_pixel(8'h55, 8'hAA);
    end_burst();
    wait_drained();

    // inactive ripple vs full-strength ripples, one far away, breath of -128
    write_cfg(RegWavePhases, 31'hFF_FFFF);
    write_cfg(RegGlowParams, 31'h80_0000);
    write_cfg(RegRipple0, {7'h7F, 8'd0, 8'h40, 8'h40});
    write_cfg(RegRipple1, {7'h00, 8'd10, 8'h80, 8'h80});
    write_cfg(RegRipple2, {7'h7F, 8'hFF, 8'h00, 8'h00});
    write_cfg(RegRipple3, {7'h01, 8'h33, 8'hFF, 8'hFF});
    send_pixel(8'h40, 8'h40); send_pixel(8'h40, 8'h00); send_pixel(8'hFF, 8'h00);
    send_pixel(8'h00, 8'hFF); send_pixel(8'hFF, 8'hFF); send_pixel(8'h00, 8'h00);
    send_pixel(8'h48, 8'h48); send_pixel(8'h40, 8'hC8);
    end_burst();
    wait_drained();
    // breath of +127, glow centred at 0x80, 0x80
    write_cfg(RegGlowParams, 31'h7F_8080);
    send_pixel(8'h80, 8'h80); send_pixel(8'h81, 8'h7F); send_pixel(8'hAA, 8'h55);
    end_burst();
    wait_drained();

    // random phases with fresh settings
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = (ph % 3 != 0);
      write_cfg(RegWavePhases, 31'($urandom) & 31'hFF_FFFF);
      write_cfg(RegGlowParams, 31'($urandom) & 31'hFF_FFFF);
      write_cfg(RegRipple0, rand_ripple());
      write_cfg(RegRipple1, rand_ripple());
      write_cfg(RegRipple2, rand_ripple());
      write_cfg(RegRipple3, rand_ripple());
      random_phase(120);
      wait_drained();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("plasma_ripple_pixel_shader_tb passed");
    else
      $display("plasma_ripple_pixel_shader_tb failed");
    $finish;
  end

endmodule
